[src/sbsm_pkg.sv]
package sbsm_pkg;

   typedef enum logic [0:0] {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      TARGET_NONE = 2'd0,
      TARGET_RAM  = 2'd1,
      TARGET_ROM  = 2'd2
   } target_type;

   typedef enum logic [0:0] {
      CSR_PRG_BANK_COUNT = 1'b0,
      CSR_CHR_SIZE_UNITS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_CONTROL = 2'd0,
      SEL_CHR0    = 2'd1,
      SEL_CHR1    = 2'd2,
      SEL_PRG     = 2'd3
   } load_select_type;

   typedef enum logic [1:0] {
      PRG_MODE_32K_A    = 2'd0,
      PRG_MODE_32K_B    = 2'd1,
      PRG_MODE_FIX_LOW  = 2'd2,
      PRG_MODE_FIX_HIGH = 2'd3
   } prg_mode_type;

   localparam logic [1:0] MIRROR_CODE_VERTICAL   = 2'd2;
   localparam logic [1:0] MIRROR_CODE_HORIZONTAL = 2'd3;

   localparam logic [2:0]  RAM_REGION        = 3'd3;
   localparam logic [4:0]  SHIFT_RESET       = 5'b10000;
   localparam logic [2:0]  SHIFT_LAST        = 3'd4;
   localparam logic [4:0]  PRG_COUNT_RESET   = 5'd16;
   localparam logic [4:0]  CHR_SIZE_RESET    = 5'd2;
   localparam logic [7:0]  CHR_HALF_STEP     = 8'd4;
   localparam int unsigned CSR_WIDTH         = 5;

   typedef struct packed {
      logic        opcode;
      logic [15:0] address;
      logic [7:0]  data;
   } request_type;

   typedef struct packed {
      logic [1:0]  target;
      logic [17:0] phys_offset;
      logic        ram_write;
      logic [7:0]  ram_data;
      logic        mirror_horizontal;
      logic        mirror_unsupported;
      logic [7:0]  chr_low_unit;
      logic [7:0]  chr_high_unit;
   } result_type;

endpackage

[src/sbsm_in_reg.sv]
module sbsm_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sbsm_pkg::request_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output sbsm_pkg::request_type item
);
   import sbsm_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   request_type item_ff;
   logic        take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[src/sbsm_core.sv]
module sbsm_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [4:0]            csr_write_data,
   input  logic                  fire,
   input  sbsm_pkg::request_type item,
   output sbsm_pkg::result_type  result
);
   import sbsm_pkg::*;

   logic [4:0] prg_bank_count_ff;
   logic [4:0] chr_size_units_ff;

   logic [4:0] shift_value_ff, shift_value_in;
   logic [2:0] shift_count_ff, shift_count_in;
   logic [2:0] control_mode_ff, control_mode_in;
   logic [3:0] prg_low_bank_ff, prg_low_bank_in;
   logic [3:0] prg_high_bank_ff, prg_high_bank_in;
   logic [7:0] chr_low_base_ff, chr_low_base_in;
   logic [7:0] chr_high_base_ff, chr_high_base_in;
   logic       mirror_mode_ff, mirror_mode_in;
   logic       unsupported_ff, unsupported_in;

   logic [4:0] shifted;
   logic [4:0] last_bank;
   logic [7:0] chr_base;
   logic       four_k;
   logic       small_chr;
   logic [3:0] read_bank;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bank_count_ff <= PRG_COUNT_RESET;
         chr_size_units_ff <= CHR_SIZE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PRG_BANK_COUNT: prg_bank_count_ff <= csr_write_data;
            CSR_CHR_SIZE_UNITS: chr_size_units_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign shifted   = {item.data[0], shift_value_ff[4:1]};
   assign last_bank = prg_bank_count_ff - 5'd1;
   assign four_k    = control_mode_ff[2];
   assign small_chr = (chr_size_units_ff[4:1] == 4'd0);

   always_comb begin
      if (small_chr) begin
         chr_base = {7'd0, shifted[0]};
      end else if (four_k) begin
         chr_base = {1'b0, shifted, 2'b00};
      end else begin
         chr_base = {1'b0, shifted[4:1], 3'b000};
      end
   end

   // mapper state update
   always_comb begin
      shift_value_in   = shift_value_ff;
      shift_count_in   = shift_count_ff;
      control_mode_in  = control_mode_ff;
      prg_low_bank_in  = prg_low_bank_ff;
      prg_high_bank_in = prg_high_bank_ff;
      chr_low_base_in  = chr_low_base_ff;
      chr_high_base_in = chr_high_base_ff;
      mirror_mode_in   = mirror_mode_ff;
      unsupported_in   = unsupported_ff;
      if (item.opcode == OP_WRITE && item.address[15]) begin
         if (item.data[7]) begin
            shift_value_in       = SHIFT_RESET;
            shift_count_in       = 3'd0;
            control_mode_in[1:0] = 2'b11;
         end else if (shift_count_ff != SHIFT_LAST) begin
            shift_value_in = shifted;
            shift_count_in = shift_count_ff + 3'd1;
         end else begin
            shift_value_in = SHIFT_RESET;
            shift_count_in = 3'd0;
            case (load_select_type'(item.address[14:13]))
               SEL_CONTROL: begin
                  control_mode_in = shifted[4:2];
                  if (shifted[1:0] == MIRROR_CODE_VERTICAL) begin
                     mirror_mode_in = 1'b0;
                  end else if (shifted[1:0] == MIRROR_CODE_HORIZONTAL) begin
                     mirror_mode_in = 1'b1;
                  end else begin
                     unsupported_in = 1'b1;
                  end
               end
               SEL_CHR0: begin
                  chr_low_base_in = chr_base;
                  if (!four_k) begin
                     chr_high_base_in = chr_base + CHR_HALF_STEP;
                  end
               end
               SEL_CHR1: begin
                  if (four_k) begin
                     chr_high_base_in = {1'b0, shifted, 2'b00};
                  end
               end
               SEL_PRG: begin
                  case (prg_mode_type'(control_mode_ff[1:0]))
                     PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                        prg_low_bank_in  = {shifted[3:1], 1'b0};
                        prg_high_bank_in = {shifted[3:1], 1'b1};
                     end
                     PRG_MODE_FIX_LOW: begin
                        prg_low_bank_in  = 4'd0;
                        prg_high_bank_in = shifted[3:0];
                     end
                     default: begin
                        prg_low_bank_in  = shifted[3:0];
                        prg_high_bank_in = last_bank[3:0];
                     end
                  endcase
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_value_ff   <= SHIFT_RESET;
         shift_count_ff   <= 3'd0;
         control_mode_ff  <= 3'd0;
         prg_low_bank_ff  <= 4'd0;
         prg_high_bank_ff <= 4'hF;
         chr_low_base_ff  <= 8'd0;
         chr_high_base_ff <= CHR_HALF_STEP;
         mirror_mode_ff   <= 1'b0;
         unsupported_ff   <= 1'b0;
      end else if (fire) begin
         shift_value_ff   <= shift_value_in;
         shift_count_ff   <= shift_count_in;
         control_mode_ff  <= control_mode_in;
         prg_low_bank_ff  <= prg_low_bank_in;
         prg_high_bank_ff <= prg_high_bank_in;
         chr_low_base_ff  <= chr_low_base_in;
         chr_high_base_ff <= chr_high_base_in;
         mirror_mode_ff   <= mirror_mode_in;
         unsupported_ff   <= unsupported_in;
      end
   end

   // bus decode
   assign read_bank = item.address[14] ? prg_high_bank_ff : prg_low_bank_ff;

   always_comb begin
      result.target      = TARGET_NONE;
      result.phys_offset = 18'd0;
      result.ram_write   = 1'b0;
      result.ram_data    = 8'd0;
      if (item.opcode == OP_READ) begin
         if (item.address[15:13] == RAM_REGION) begin
            result.target      = TARGET_RAM;
            result.phys_offset = {5'd0, item.address[12:0]};
         end else if (item.address[15]) begin
            result.target      = TARGET_ROM;
            result.phys_offset = {read_bank, item.address[13:0]};
         end
      end else if (!item.address[15]) begin
         result.target      = TARGET_RAM;
         result.phys_offset = {5'd0, item.address[12:0]};
         result.ram_write   = 1'b1;
         result.ram_data    = item.data;
      end
      result.mirror_horizontal  = mirror_mode_in;
      result.mirror_unsupported = unsupported_in;
      result.chr_low_unit       = chr_low_base_in;
      result.chr_high_unit      = chr_high_base_in;
   end

   shift_count_range: assert property (@(posedge clock) disable iff (reset)
      shift_count_ff <= SHIFT_LAST)
      else $error("shift count out of range");

   clear_forces_mode: assert property (@(posedge clock) disable iff (reset)
      fire && item.opcode == OP_WRITE && item.address[15] && item.data[7]
      |=> shift_value_ff == SHIFT_RESET && shift_count_ff == 3'd0
          && control_mode_ff[1:0] == 2'b11)
      else $error("serial clear did not reset shift register");

   idle_holds_map: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(prg_low_bank_ff) && $stable(prg_high_bank_ff)
                && $stable(chr_low_base_ff) && $stable(shift_count_ff))
      else $error("mapping changed without a transaction");

   flag_sticky: assert property (@(posedge clock) disable iff (reset)
      unsupported_ff |=> unsupported_ff)
      else $error("unsupported mirroring flag dropped");

endmodule

[src/sbsm_out_reg.sv]
module sbsm_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  sbsm_pkg::result_type result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sbsm_pkg::result_type rsp_item
);
   import sbsm_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign advance = item_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = result_ff;

endmodule

[src/serial_bank_switch_mapper_unit.sv]
// channel   direction  ports
// req       in         req_valid, req_stall, req_opcode, req_address, req_data
// rsp       out        rsp_valid, rsp_stall, rsp_target ... rsp_chr_high_unit
// csr       in         csr_write_enable, csr_index, csr_write_data
//
// one transaction per cycle without rsp_stall; requests pass the input, then the result register
// mapper state updates as a request moves from the input register to the result register
// reset is synchronous: banks, shift register and flags return to power-up values
// rsp_stall holds the result register; req_stall rises only when both registers are full
// and rsp_stall is high
module serial_bank_switch_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_target,
   output logic [17:0] rsp_phys_offset,
   output logic        rsp_ram_write,
   output logic [7:0]  rsp_ram_data,
   output logic        rsp_mirror_horizontal,
   output logic        rsp_mirror_unsupported,
   output logic [7:0]  rsp_chr_low_unit,
   output logic [7:0]  rsp_chr_high_unit,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [4:0]  csr_write_data
);
   import sbsm_pkg::*;

   request_type req_item;
   request_type item;
   logic        item_valid;
   logic        advance;
   result_type  result;
   result_type  rsp_item;

   assign req_item.opcode  = req_opcode;
   assign req_item.address = req_address;
   assign req_item.data    = req_data;

   sbsm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sbsm_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fire             (advance),
      .item             (item),
      .result           (result)
   );

   sbsm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_target             = rsp_item.target;
   assign rsp_phys_offset        = rsp_item.phys_offset;
   assign rsp_ram_write          = rsp_item.ram_write;
   assign rsp_ram_data           = rsp_item.ram_data;
   assign rsp_mirror_horizontal  = rsp_item.mirror_horizontal;
   assign rsp_mirror_unsupported = rsp_item.mirror_unsupported;
   assign rsp_chr_low_unit       = rsp_item.chr_low_unit;
   assign rsp_chr_high_unit      = rsp_item.chr_high_unit;

endmodule
